/* rtl/core/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master with 16-bit register address.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // Item commands carried in the input tuser
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_QUEUE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_ACK_TIMEOUT    = 1'b1;

  // Configuration reset values
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd20;
  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

  // Default depth of the write data buffer
  localparam int MAX_BYTES_DEF = 16;

  // Port widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 8;

  // Classified item passed from the front to the engine
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] reg_address;
    logic [4:0]  byte_count;
    logic        over_max;
    logic [7:0]  write_byte;
    logic        sda_in;
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/i2cm_ram.sv */
// ----------------------------------------------------------------------------
// i2cm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/i2cm_front.sv */
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: unpack the stream item, classify it and flag oversize counts.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front
  import i2cm_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]           in_tuser,
  input  wire logic                 q_full,
  output logic                      q_push,
  output item_t                     q_item
);

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Unpack and classify
  always_comb begin
    q_item.cmd         = cmd_t'(in_tuser);
    q_item.reg_address = in_tdata[15:0];
    q_item.byte_count  = in_tdata[20:16];
    q_item.over_max    = (32'(in_tdata[20:16]) > MAX_BYTES);
    q_item.write_byte  = in_tdata[28:21];
    q_item.sda_in      = in_tdata[29];
  end

endmodule

`default_nettype wire

/* rtl/core/i2cm_queue.sv */
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry item queue between the front and the bus engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_queue
  import i2cm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  item_t      push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       pop_valid,
  output item_t      pop_item
);

  item_t       mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/i2cm_engine.sv */
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus engine: at most one bus phase per tick item, buffer writes, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_engine
  import i2cm_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  q_valid,
  input  item_t                      q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_TX_LOW, PH_TX_HIGH, PH_ACK_WAIT,
    PH_ACK_HIGH, PH_RS_A, PH_RS_B, PH_RS_C, PH_RX_LOW, PH_RX_HIGH,
    PH_MA_LOW, PH_MA_HIGH, PH_STOP_A, PH_STOP_B
  } phase_t;

  typedef enum logic [2:0] {
    ST_DEV, ST_ADDR_HI, ST_ADDR_LO, ST_RD_DEV, ST_DATA
  } stage_t;

  // Bus state
  phase_t       phase_r, phase_nxt;
  stage_t       stage_r, stage_nxt;
  logic [3:0]   bit_r, bit_nxt;
  logic [CW-1:0] byte_r, byte_nxt;
  logic [7:0]   shift_r, shift_nxt;
  logic [7:0]   wait_r, wait_nxt;
  logic [15:0]  addr_r, addr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic         rd_r, rd_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic         err_r, err_nxt;
  logic [6:0]   dev_r;
  logic [7:0]   tmo_r;

  // Result register
  logic         out_valid_r;
  logic         out_scl_r, out_sda_r, out_drive_r;
  logic [7:0]   out_rdata_r;
  logic         out_rvalid_r, out_last_r, out_busy_r, out_done_r, out_err_r;

  // Per-item results
  logic         scl, sda, drive, rvalid, rlast, done, derr;
  logic [7:0]   rdata;

  // Helpers
  logic [CW:0]  byte_inc;
  logic [CW:0]  ma_inc;
  logic [8:0]   wait_inc;
  logic [CW:0]  raddr_full;
  logic         ram_we;
  logic [7:0]   ram_rdata;

  // Data buffer: written at the fill point, read at the next byte to send
  assign ram_we     = q_pop && (phase_r == PH_IDLE) && (q_item.cmd == CMD_QUEUE)
                      && (32'(fill_r) < MAX_BYTES);
  assign raddr_full = (stage_r == ST_DATA) ? ({1'b0, byte_r} + (CW+1)'(1))
                                           : {1'b0, byte_r};

  i2cm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_txbuf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (q_item.write_byte),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Take an item when the result register is free or being drained
  assign q_pop = q_valid && (!out_valid_r || out_tready);

  assign byte_inc = {1'b0, byte_r} + (CW+1)'(1);
  assign wait_inc = {1'b0, wait_r} + 9'd1;

  // Next bus state
  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    addr_nxt  = addr_r;
    count_nxt = count_r;
    rd_nxt    = rd_r;
    fill_nxt  = fill_r;
    err_nxt   = err_r;
    rvalid    = 1'b0;
    rlast     = 1'b0;
    rdata     = 8'd0;
    done      = 1'b0;
    derr      = 1'b0;
    if (q_pop) begin
      if (phase_r == PH_IDLE) begin
        unique case (q_item.cmd)
          CMD_TICK: begin
          end
          CMD_QUEUE: begin
            if (ram_we) begin
              fill_nxt = fill_r + CW'(1);
            end
          end
          CMD_READ, CMD_WRITE: begin
            addr_nxt  = q_item.reg_address;
            count_nxt = q_item.over_max ? CW'(MAX_BYTES) : CW'(q_item.byte_count);
            rd_nxt    = (q_item.cmd == CMD_READ);
            stage_nxt = ST_DEV;
            byte_nxt  = '0;
            bit_nxt   = 4'd0;
            wait_nxt  = 8'd0;
            err_nxt   = 1'b0;
            phase_nxt = PH_START_A;
          end
        endcase
      end else if (q_item.cmd == CMD_TICK) begin
        unique case (phase_r)
          PH_START_A: phase_nxt = PH_START_B;
          PH_START_B: begin
            stage_nxt = ST_DEV;
            shift_nxt = {dev_r, 1'b0};
            bit_nxt   = 4'd0;
            phase_nxt = PH_TX_LOW;
          end
          PH_TX_LOW: phase_nxt = PH_TX_HIGH;
          PH_TX_HIGH: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_r + 4'd1;
            if (bit_r == 4'd7) begin
              wait_nxt  = 8'd0;
              phase_nxt = PH_ACK_WAIT;
            end else begin
              phase_nxt = PH_TX_LOW;
            end
          end
          PH_ACK_WAIT: begin
            if (q_item.sda_in) begin
              if (wait_inc > {1'b0, tmo_r}) begin
                err_nxt   = 1'b1;
                phase_nxt = PH_STOP_A;
              end else begin
                wait_nxt = wait_inc[7:0];
              end
            end else begin
              phase_nxt = PH_ACK_HIGH;
            end
          end
          PH_ACK_HIGH: begin
            // Pick the next byte of the transaction
            unique case (stage_r)
              ST_DEV: begin
                stage_nxt = ST_ADDR_HI;
                shift_nxt = addr_r[15:8];
                bit_nxt   = 4'd0;
                phase_nxt = PH_TX_LOW;
              end
              ST_ADDR_HI: begin
                stage_nxt = ST_ADDR_LO;
                shift_nxt = addr_r[7:0];
                bit_nxt   = 4'd0;
                phase_nxt = PH_TX_LOW;
              end
              ST_ADDR_LO: begin
                priority if (rd_r) begin
                  phase_nxt = PH_RS_A;
                end else if (count_r == '0) begin
                  phase_nxt = PH_STOP_A;
                end else begin
                  stage_nxt = ST_DATA;
                  byte_nxt  = '0;
                  shift_nxt = ram_rdata;
                  bit_nxt   = 4'd0;
                  phase_nxt = PH_TX_LOW;
                end
              end
              ST_RD_DEV: begin
                if (count_r == '0) begin
                  phase_nxt = PH_STOP_A;
                end else begin
                  byte_nxt  = '0;
                  shift_nxt = 8'd0;
                  bit_nxt   = 4'd0;
                  phase_nxt = PH_RX_LOW;
                end
              end
              default: begin
                byte_nxt = byte_inc[CW-1:0];
                if (byte_inc >= {1'b0, count_r}) begin
                  phase_nxt = PH_STOP_A;
                end else begin
                  shift_nxt = ram_rdata;
                  bit_nxt   = 4'd0;
                  phase_nxt = PH_TX_LOW;
                end
              end
            endcase
          end
          PH_RS_A: phase_nxt = PH_RS_B;
          PH_RS_B: phase_nxt = PH_RS_C;
          PH_RS_C: begin
            stage_nxt = ST_RD_DEV;
            shift_nxt = {dev_r, 1'b1};
            bit_nxt   = 4'd0;
            phase_nxt = PH_TX_LOW;
          end
          PH_RX_LOW: phase_nxt = PH_RX_HIGH;
          PH_RX_HIGH: begin
            shift_nxt = {shift_r[6:0], q_item.sda_in};
            bit_nxt   = bit_r + 4'd1;
            if (bit_r == 4'd7) begin
              rvalid    = 1'b1;
              rdata     = {shift_r[6:0], q_item.sda_in};
              rlast     = (byte_inc == {1'b0, count_r});
              phase_nxt = PH_MA_LOW;
            end else begin
              phase_nxt = PH_RX_LOW;
            end
          end
          PH_MA_LOW: phase_nxt = PH_MA_HIGH;
          PH_MA_HIGH: begin
            byte_nxt = byte_inc[CW-1:0];
            if (byte_inc >= {1'b0, count_r}) begin
              phase_nxt = PH_STOP_A;
            end else begin
              shift_nxt = 8'd0;
              bit_nxt   = 4'd0;
              phase_nxt = PH_RX_LOW;
            end
          end
          PH_STOP_A: phase_nxt = PH_STOP_B;
          default: begin
            // Stop complete: report and release the bus
            done      = 1'b1;
            derr      = err_r;
            err_nxt   = 1'b0;
            fill_nxt  = '0;
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Line levels of the phase just entered
  assign ma_inc = {1'b0, byte_nxt} + (CW+1)'(1);

  always_comb begin
    unique case (phase_nxt)
      PH_START_A, PH_RS_B: begin
        scl = 1'b1; sda = 1'b1; drive = 1'b1;
      end
      PH_START_B, PH_RS_C, PH_STOP_B: begin
        scl = 1'b1; sda = 1'b0; drive = 1'b1;
      end
      PH_TX_LOW: begin
        scl = 1'b0; sda = shift_nxt[7]; drive = 1'b1;
      end
      PH_TX_HIGH: begin
        scl = 1'b1; sda = shift_nxt[7]; drive = 1'b1;
      end
      PH_ACK_WAIT, PH_RX_LOW: begin
        scl = 1'b0; sda = 1'b1; drive = 1'b0;
      end
      PH_ACK_HIGH, PH_RX_HIGH: begin
        scl = 1'b1; sda = 1'b1; drive = 1'b0;
      end
      PH_RS_A: begin
        scl = 1'b0; sda = 1'b1; drive = 1'b1;
      end
      PH_MA_LOW, PH_MA_HIGH: begin
        scl   = (phase_nxt == PH_MA_HIGH);
        sda   = (ma_inc == {1'b0, count_nxt});
        drive = 1'b1;
      end
      PH_STOP_A: begin
        scl = 1'b0; sda = 1'b0; drive = 1'b1;
      end
      default: begin
        scl = 1'b1; sda = 1'b1; drive = done;
      end
    endcase
  end

  // Hold state, configuration and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      stage_r     <= ST_DEV;
      bit_r       <= 4'd0;
      byte_r      <= '0;
      shift_r     <= 8'd0;
      wait_r      <= 8'd0;
      addr_r      <= 16'd0;
      count_r     <= '0;
      rd_r        <= 1'b0;
      fill_r      <= '0;
      err_r       <= 1'b0;
      dev_r       <= DEVICE_ADDRESS_RST;
      tmo_r       <= ACK_TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
      addr_r  <= addr_nxt;
      count_r <= count_nxt;
      rd_r    <= rd_nxt;
      fill_r  <= fill_nxt;
      err_r   <= err_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEVICE_ADDRESS: dev_r <= cfg_data[6:0];
          CFG_ACK_TIMEOUT:    tmo_r <= cfg_data[7:0];
        endcase
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_scl_r    <= scl;
      out_sda_r    <= sda;
      out_drive_r  <= drive;
      out_rdata_r  <= rdata;
      out_rvalid_r <= rvalid;
      out_last_r   <= rvalid && rlast;
      out_busy_r   <= (phase_nxt != PH_IDLE);
      out_done_r   <= done;
      out_err_r    <= derr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_err_r, out_done_r, out_busy_r, out_rvalid_r,
                       out_rdata_r, out_drive_r, out_sda_r, out_scl_r};

  // A taken item always leaves a result behind
  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("item taken without a result");

  // A received byte is followed by the master acknowledge phase
  a_rx_then_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rvalid_r) |->
      (!out_scl_r && out_drive_r && (out_sda_r == out_last_r)))
    else $error("received byte not followed by master acknowledge");

  // An error is reported only with the closing stop
  a_err_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_done_r && !out_busy_r))
    else $error("ack error outside the done result");

  // The buffer is never filled past its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= MAX_BYTES)
    else $error("buffer fill beyond depth");

endmodule

`default_nettype wire

/* rtl/core/i2c_master_reg16_burst_top.sv */
// ----------------------------------------------------------------------------
// i2c_master_reg16_burst_top
// I2C master for register transactions with a 16-bit register address.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  in_       slave      in_tvalid/in_tready   tdata: reg_address, byte_count,
//                                             write_byte, sda_in; tuser: command
//  out_      master     out_tvalid/out_tready tdata: bus levels and status;
//                                             tlast: last_byte
//  cfg_      write      cfg_we                cfg_index, cfg_data
//
//  One item per clock sustained while out_tready stays high; each item's result
//  passes through a queue entry, then the result register, before it is
//  presented on the out_ channel.
//  Each tick item outside idle advances the bus engine by at most one phase.
//  The two-entry queue takes items until full while a result waits on out_tready.
//  Synchronous active-low reset clears control state and loads the register
//  defaults; the write data buffer holds no defined contents until written.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_reg16_burst_top
  import i2cm_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [15:0] reg_address, [20:16] byte_count, [28:21] write_byte, [29] sda_in
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] command
  input  wire logic [1:0]            in_tuser,
  // Result items
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [10:3] read_data,
  // [11] read_valid, [12] busy_res, [13] done_res, [14] ack_error
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  // Configuration writes
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;

  i2cm_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  i2cm_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
